[src/ssig_pkg.sv]
package ssig_pkg;

    // Fraction bits of a position inside one table segment.
    localparam int FRAC_W = 20;

    // Configuration register indexes.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER = 1'b1;

    // Register reset values: gain 1.0 and centre 0.0, both Q8.8.
    localparam logic [15:0] GAIN_RESET   = 16'h0100;
    localparam logic [15:0] CENTER_RESET = 16'h0000;

    // Item kinds carried in tuser.
    localparam logic OP_FORWARD  = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    // Argument limits, +/-8.0 in Q16.16.
    localparam logic signed [32:0] Z_POS_LIMIT = 33'sd524288;
    localparam logic signed [32:0] Z_NEG_LIMIT = -33'sd524288;

    // Restoring long division, used only while the table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table entry k of segs segments: sigmoid at z = -8 + 16k/segs, Q0.16.
    // The exponential is a truncated Taylor series in Q32.
    function automatic logic [15:0] sig_entry(input int k, input int segs);
        logic [63:0] step;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] y;
        longint      z;
        logic        done;
        step = udiv64(64'(k) * 64'd1048576, 64'(segs));
        z    = longint'(step) - 64'sd524288;
        u    = (z < 0) ? 64'(-z) : 64'(z);
        term = 64'h1_0000_0000;
        sum  = 64'h1_0000_0000;
        done = 1'b0;
        for (int n = 1; n <= 64; n++)
        begin
            if (!done)
            begin
                term = udiv64((term * u) >> 16, 64'(n));
                if (term == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    sum = sum + term;
                end
            end
        end
        den = sum + 64'h1_0000_0000;
        num = (z >= 0) ? (sum << 16) : (64'd1 << 48);
        y   = udiv64(num + (den >> 1), den);
        return (y > 64'd65535) ? 16'hFFFF : y[15:0];
    endfunction

endpackage

[src/scaled_sigmoid_with_gradient_unit.sv]
// Each accepted input word passes through the registered stages below, in order, to its result word.
// Throughput: one word per cycle while the output is not stalled; each stage moves on when it is empty or
// the stage after it moves, so bubbles close up behind a stalled output.
// Reset clears every valid bit and sets gain to 1.0 and centre to 0.0.
// The segment table is constant logic and needs no fill after reset.
module scaled_sigmoid_with_gradient_unit #(
    parameter int TABLE_SEGMENTS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_write,
    input  logic [ssig_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,   // x_value, act_value, grad_in
    input  logic                             s_tuser,   // operation
    // Output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata    // activation, grad_out, saturated, zeros
);

    localparam int IDX_W = $clog2(TABLE_SEGMENTS + 1);
    localparam int FW    = ssig_pkg::FRAC_W;
    localparam int POS_W = FW + IDX_W;

    // Constant segment table.
    logic [15:0] sig_tab [TABLE_SEGMENTS+1];

    for (genvar k = 0; k <= TABLE_SEGMENTS; k++)
    begin : g_tab
        localparam logic [15:0] ENTRY = ssig_pkg::sig_entry(k, TABLE_SEGMENTS);
        assign sig_tab[k] = ENTRY;
    end

    // Configuration registers.
    logic signed [15:0] gain_reg;
    logic signed [15:0] center_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= ssig_pkg::GAIN_RESET;
            center_reg <= ssig_pkg::CENTER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssig_pkg::REG_GAIN:   gain_reg   <= cfg_data;
                ssig_pkg::REG_CENTER: center_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage 1: argument product for forward; y(1-y) and |grad|*|gain| for backward.
    logic signed [15:0] x_in;
    logic        [15:0] y_in;
    logic signed [15:0] gi_in;
    logic signed [16:0] diff_x;
    logic        [16:0] one_minus_y;
    logic        [32:0] p_full;
    logic        [15:0] mag_grad;
    logic        [15:0] mag_gain;
    logic        [31:0] mgma_full;

    logic               op1_reg,   op1_next;
    logic signed [32:0] z1_reg,    z1_next;
    logic        [30:0] p1_reg,    p1_next;
    logic        [30:0] mgma1_reg, mgma1_next;
    logic               neg1_reg,  neg1_next;

    always_comb
    begin
        x_in        = s_tdata[15:0];
        y_in        = s_tdata[31:16];
        gi_in       = s_tdata[47:32];
        diff_x      = {x_in[15], x_in} - {center_reg[15], center_reg};
        z1_next     = gain_reg * diff_x;
        one_minus_y = 17'h10000 - {1'b0, y_in};
        p_full      = y_in * one_minus_y;
        p1_next     = p_full[30:0];
        mag_grad    = gi_in[15] ? 16'(-gi_in) : gi_in;
        mag_gain    = gain_reg[15] ? 16'(-gain_reg) : gain_reg;
        mgma_full   = mag_grad * mag_gain;
        mgma1_next  = mgma_full[30:0];
        neg1_next   = gi_in[15] ^ gain_reg[15];
        op1_next    = s_tuser;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= op1_next;
            z1_reg    <= z1_next;
            p1_reg    <= p1_next;
            mgma1_reg <= mgma1_next;
            neg1_reg  <= neg1_next;
        end
    end

    // Stage 2: clip test and segment position; full backward magnitude.
    logic [FW-1:0]    off;
    logic [POS_W-1:0] pos;
    logic [61:0]      mag_full;

    logic              op2_reg,   op2_next;
    logic              zsat2_reg, zsat2_next;
    logic              zpos2_reg, zpos2_next;
    logic [IDX_W-1:0]  seg2_reg,  seg2_next;
    logic [FW-1:0]     fr2_reg,   fr2_next;
    logic [60:0]       mag2_reg,  mag2_next;
    logic              neg2_reg,  neg2_next;

    always_comb
    begin
        zpos2_next = (z1_reg >= ssig_pkg::Z_POS_LIMIT);
        zsat2_next = zpos2_next || (z1_reg <= ssig_pkg::Z_NEG_LIMIT);
        off        = z1_reg[FW-1:0] + {1'b1, {(FW-1){1'b0}}};
        pos        = POS_W'(off) * POS_W'(TABLE_SEGMENTS);
        seg2_next  = pos[POS_W-1:FW];
        fr2_next   = pos[FW-1:0];
        mag_full   = mgma1_reg * p1_reg;
        mag2_next  = mag_full[60:0];
        neg2_next  = neg1_reg;
        op2_next   = op1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg   <= op2_next;
            zsat2_reg <= zsat2_next;
            zpos2_reg <= zpos2_next;
            seg2_reg  <= seg2_next;
            fr2_reg   <= fr2_next;
            mag2_reg  <= mag2_next;
            neg2_reg  <= neg2_next;
        end
    end

    // Stage 3: table reads for forward; rounding and clipping for backward.
    logic [15:0] hi_val;
    logic [60:0] mag_rnd;
    logic [20:0] r_mag;

    logic          op3_reg,    op3_next;
    logic          sat3_reg,   sat3_next;
    logic          zsat3_reg,  zsat3_next;
    logic [15:0]   actc3_reg,  actc3_next;
    logic [15:0]   lo3_reg,    lo3_next;
    logic [15:0]   dlt3_reg,   dlt3_next;
    logic [FW-1:0] fr3_reg,    fr3_next;
    logic [15:0]   grad3_reg,  grad3_next;

    always_comb
    begin
        lo3_next   = sig_tab[seg2_reg];
        hi_val     = sig_tab[seg2_reg + IDX_W'(1)];
        dlt3_next  = hi_val - lo3_next;
        fr3_next   = fr2_reg;
        actc3_next = zpos2_reg ? 16'hFFFF : 16'h0000;
        zsat3_next = zsat2_reg;
        mag_rnd    = mag2_reg + (61'd1 << 39);
        r_mag      = mag_rnd[60:40];
        if (!neg2_reg && (r_mag > 21'd32767))
        begin
            grad3_next = 16'h7FFF;
            sat3_next  = 1'b1;
        end
        else if (neg2_reg && (r_mag > 21'd32768))
        begin
            grad3_next = 16'h8000;
            sat3_next  = 1'b1;
        end
        else
        begin
            grad3_next = neg2_reg ? 16'(-r_mag[15:0]) : r_mag[15:0];
            sat3_next  = 1'b0;
        end
        if (op2_reg == ssig_pkg::OP_FORWARD)
        begin
            sat3_next = zsat2_reg;
        end
        op3_next = op2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            op3_reg   <= op3_next;
            sat3_reg  <= sat3_next;
            zsat3_reg <= zsat3_next;
            actc3_reg <= actc3_next;
            lo3_reg   <= lo3_next;
            dlt3_reg  <= dlt3_next;
            fr3_reg   <= fr3_next;
            grad3_reg <= grad3_next;
        end
    end

    // Stage 4: interpolation between segment ends, rounded half up; output word.
    logic [35:0] interp_prod;
    logic [36:0] interp_rnd;
    logic [15:0] interp_val;

    logic        out_op_reg;
    logic [15:0] act_reg,  act_next;
    logic [15:0] grad_reg, grad_next;
    logic        sat_reg;

    always_comb
    begin
        interp_prod = dlt3_reg * fr3_reg;
        interp_rnd  = {1'b0, interp_prod} + (37'd1 << (FW - 1));
        interp_val  = lo3_reg + interp_rnd[FW+15:FW];
        if (op3_reg == ssig_pkg::OP_BACKWARD)
        begin
            act_next  = 16'h0000;
            grad_next = grad3_reg;
        end
        else
        begin
            act_next  = zsat3_reg ? actc3_reg : interp_val;
            grad_next = 16'h0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            out_op_reg <= op3_reg;
            act_reg    <= act_next;
            grad_reg   <= grad_next;
            sat_reg    <= sat3_reg;
        end
    end

    assign m_tdata = {7'b0, sat_reg, grad_reg, act_reg};

    // Checks on the pipeline and the result word.
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_one_result_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (act_reg == 16'h0000 || grad_reg == 16'h0000))
        else $error("forward and backward results both non-zero");

    a_bwd_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_op_reg == ssig_pkg::OP_BACKWARD && sat_reg)
            |-> (grad_reg == 16'h7FFF || grad_reg == 16'h8000))
        else $error("clipped gradient is not a limit value");

    a_fwd_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_op_reg == ssig_pkg::OP_FORWARD && sat_reg)
            |-> (act_reg == 16'hFFFF || act_reg == 16'h0000))
        else $error("clipped activation is not a limit value");

endmodule

[sim/scaled_sigmoid_with_gradient_unit_tb.sv]
module scaled_sigmoid_with_gradient_unit_tb;

    localparam int SEGS        = 32;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 200;

    // One input word and one result word, split into their fields.
    typedef struct packed {
        logic        op;
        logic [15:0] x;
        logic [15:0] act;
        logic [15:0] grad;
    } word_t;

    typedef struct packed {
        logic [15:0] activation;
        logic [15:0] grad_out;
        logic        saturated;
    } result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [ssig_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                    cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [47:0]                    s_tdata = '0;    // x_value, act_value, grad_in
    logic                           s_tuser = 1'b0;  // operation
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [39:0]                    m_tdata;         // activation, grad_out, saturated, zeros

    // Local copy of the configuration and of the sigmoid segment ends.
    logic signed [15:0]   model_gain = ssig_pkg::GAIN_RESET;
    logic signed [15:0]   model_center = ssig_pkg::CENTER_RESET;
    longint unsigned      sigmoid_lut [0:SEGS];

    word_t                pending_words[$];
    result_t              expected_results[$];
    word_t                drive_word;
    result_t              head_result;
    result_t              got_result;

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   words_in = 0;
    int                   mismatches = 0;
    int                   quiet_cycles = 0;
    int                   stall_from = 32'h7fff_ffff;
    int                   hold_left = 0;
    logic                 stall_done = 1'b0;
    logic                 s_taken = 1'b0;

    scaled_sigmoid_with_gradient_unit #(
        .TABLE_SEGMENTS (SEGS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Sigmoid of z (Q16.16) as Q0.16, with exp from a Taylor series in Q32.
    function automatic longint unsigned sigmoid_point(longint z);
        longint unsigned u;
        longint unsigned term;
        longint unsigned total;
        longint unsigned den;
        longint unsigned num;
        longint unsigned y;
        u     = (z < 0) ? -z : z;
        term  = 64'h1_0000_0000;
        total = 64'h1_0000_0000;
        for (int n = 1; n <= 64; n++)
        begin
            term = ((term * u) >> 16) / n;
            if (term == 0)
            begin
                break;
            end
            total = total + term;
        end
        den = total + 64'h1_0000_0000;
        num = (z >= 0) ? (total << 16) : (64'd1 << 48);
        y   = (num + den / 2) / den;
        return (y > 65535) ? 64'd65535 : y;
    endfunction

    // Expected result of one word under the current gain and centre.
    function automatic result_t predict_activation(word_t w);
        result_t         res;
        longint          gl;
        longint          gi;
        longint          z;
        longint          pos;
        longint          seg;
        longint          fr;
        longint          v;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mix;
        longint unsigned yv;
        longint unsigned p;
        longint unsigned mg;
        longint unsigned ma;
        longint unsigned mag;
        longint unsigned r;
        bit              neg;
        res = '0;
        gl  = longint'(model_gain);
        if (w.op == ssig_pkg::OP_FORWARD)
        begin
            z = gl * (longint'($signed(w.x)) - longint'(model_center));
            if (z >= 524288)
            begin
                res.activation = 16'hFFFF;
                res.saturated  = 1'b1;
            end
            else if (z <= -524288)
            begin
                res.saturated = 1'b1;
            end
            else
            begin
                // Position within the table: segment index and 20-bit fraction.
                pos = (z + 524288) * SEGS;
                seg = pos >> 20;
                fr  = pos & 64'hF_FFFF;
                if (seg >= SEGS)
                begin
                    seg = SEGS - 1;
                end
                lo  = sigmoid_lut[seg];
                hi  = sigmoid_lut[seg + 1];
                mix = (lo * ((64'd1 << 20) - fr) + hi * fr + (64'd1 << 19)) >> 20;
                res.activation = (mix > 65535) ? 16'hFFFF : mix[15:0];
            end
        end
        else
        begin
            yv  = w.act;
            p   = yv * (64'd65536 - yv);
            gi  = longint'($signed(w.grad));
            neg = (gi < 0) != (gl < 0);
            mg  = (gi < 0) ? -gi : gi;
            ma  = (gl < 0) ? -gl : gl;
            mag = mg * p * ma;
            if (mg == 0 || ma == 0 || p == 0)
            begin
                neg = 1'b0;
            end
            // Round the Q16.48 magnitude to Q8.8, ties away from zero.
            r = (mag + (64'd1 << 39)) >> 40;
            if (!neg && r > 32767)
            begin
                v = 32767;
                res.saturated = 1'b1;
            end
            else if (neg && r > 32768)
            begin
                v = -32768;
                res.saturated = 1'b1;
            end
            else
            begin
                v = neg ? -longint'(r) : longint'(r);
            end
            res.grad_out = v[15:0];
        end
        return res;
    endfunction

    task automatic queue_word(logic op, int x, int a, int g);
        word_t w;
        w.op   = op;
        w.x    = x[15:0];
        w.act  = a[15:0];
        w.grad = g[15:0];
        pending_words.push_back(w);
    endtask

    // Random word: forward samples mostly land inside the interpolated range.
    task automatic queue_random_word();
        int  xv;
        int  av;
        int  span;
        int  gabs;
        gabs = (model_gain < 0) ? -int'(model_gain) : int'(model_gain);
        if ($urandom_range(0, 1) == 0)
        begin
            xv = int'($urandom_range(0, 65535)) - 32768;
            if (gabs != 0 && $urandom_range(0, 9) < 7)
            begin
                span = 524288 / gabs + 2;
                xv   = int'(model_center) + int'($urandom_range(0, 2 * span)) - span;
                if (xv < -32768 || xv > 32767)
                begin
                    xv = int'($urandom_range(0, 65535)) - 32768;
                end
            end
            queue_word(ssig_pkg::OP_FORWARD, xv, $urandom, $urandom);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: av = 0;
                1: av = 65535;
                2: av = 32768;
                3: av = 1;
                default: av = $urandom_range(0, 65535);
            endcase
            queue_word(ssig_pkg::OP_BACKWARD, $urandom, av, $urandom);
        end
    endtask

    task automatic write_reg(logic [ssig_pkg::REG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        if (idx == ssig_pkg::REG_GAIN)
        begin
            model_gain = value[15:0];
        end
        else
        begin
            model_center = value[15:0];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every word has gone in and every result has come out.
    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            if (mismatches < 10)
            begin
                $display("mismatch on %s: expected %0h, got %0h", field, want, got);
            end
            mismatches = mismatches + 1;
        end
    endtask

    // Sender: offers the next pending word at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drive_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drive_word.grad, drive_word.act, drive_word.x};
                s_tuser  <= drive_word.op;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the pipeline up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!stall_done && words_in >= stall_from)
        begin
            hold_left  <= HOLD_CYCLES;
            stall_done <= 1'b1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Input side: predict the result of each accepted word.
    always @(posedge clk)
    begin
        s_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(predict_activation({s_tuser, s_tdata[15:0],
                                                           s_tdata[31:16], s_tdata[47:32]}));
            words_in <= words_in + 1;
        end
    end

    // Output side: compare each result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = {m_tdata[15:0], m_tdata[31:16], m_tdata[32]};
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $display("unexpected result word %h", m_tdata);
                end
                mismatches = mismatches + 1;
            end
            else
            begin
                head_result = expected_results.pop_front();
                check_field("activation", head_result.activation, got_result.activation);
                check_field("grad_out", head_result.grad_out, got_result.grad_out);
                check_field("saturated", head_result.saturated, got_result.saturated);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        int new_gain;
        int new_center;
        for (int k = 0; k <= SEGS; k++)
        begin
            sigmoid_lut[k] = sigmoid_point((longint'(k) * 1048576) / SEGS - 524288);
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 24;
        recv_idle_pct = 52;

        // Reset settings: gain 1.0, centre 0, so clipping starts at x = +/-2048.
        queue_word(ssig_pkg::OP_FORWARD, 0, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, -32768, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 32767, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 2048, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 2047, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, -2048, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, -2047, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 1, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, -1000, $urandom, $urandom);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 0, 32767);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 65535, -32768);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 32768, -32768);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 32768, 0);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 1, 1);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 12345, -100);
        drain();

        // Steepest positive gain: gradient clips both ways, z clips just past x = 16.
        write_reg(ssig_pkg::REG_GAIN, 32767);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 32768, 32767);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 32768, -32768);
        queue_word(ssig_pkg::OP_BACKWARD, $urandom, 0, -32768);
        queue_word(ssig_pkg::OP_FORWARD, 15, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 16, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, 17, $urandom, $urandom);
        queue_word(ssig_pkg::OP_FORWARD, -17, $urandom, $urandom);
        drain();

        // Random phases, each under its own gain and centre.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin new_gain = 256;    new_center = 0;      end
                1: begin new_gain = -32768; new_center = 32767;  end
                2: begin new_gain = 32767;  new_center = -32768; end
                3: begin new_gain = 0;      new_center = int'($urandom_range(0, 65535)) - 32768; end
                4: begin new_gain = int'($urandom_range(0, 65535)) - 32768;
                         new_center = int'($urandom_range(0, 65535)) - 32768; end
                5: begin new_gain = 1;      new_center = 0;      end
                default: begin new_gain = int'($urandom_range(0, 4096)) - 2048;
                               new_center = int'($urandom_range(0, 1024)) - 512; end
            endcase
            write_reg(ssig_pkg::REG_GAIN, new_gain);
            write_reg(ssig_pkg::REG_CENTER, new_center);
            if (ph < 2)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 52;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 4)
            begin
                stall_from = words_in + 40;
            end
            repeat (PHASE_WORDS) queue_random_word();
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/ssig_pkg.sv
src/scaled_sigmoid_with_gradient_unit.sv
sim/scaled_sigmoid_with_gradient_unit_tb.sv
